// File: rtl/sbpos_pkg.sv
// ----------------------------------------------------------------------------
// sbpos_pkg
// Shared types, codes and the control store for the statistics buffer pool
// oldest-select block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpos_pkg;

  localparam int NUM_BUFFERS = 8;
  localparam int BUF_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int STAMP_W     = 32;

  // request op codes
  localparam logic [2:0] OP_FRAME_END = 3'd0;
  localparam logic [2:0] OP_ARM_NEXT  = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_OVERFLOW  = 3'd4;
  localparam logic [2:0] OP_BUSY      = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_BUF = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  typedef logic [3:0] upc_t;

  // control store addresses
  localparam upc_t U_IDLE     = 4'd0;
  localparam upc_t U_FEND     = 4'd1;
  localparam upc_t U_ARM      = 4'd2;
  localparam upc_t U_SCAN_E   = 4'd3;
  localparam upc_t U_ARM_FIN  = 4'd4;
  localparam upc_t U_READ     = 4'd5;
  localparam upc_t U_SCAN_F   = 4'd6;
  localparam upc_t U_READ_FIN = 4'd7;
  localparam upc_t U_CLEAR    = 4'd8;
  localparam upc_t U_OVF      = 4'd9;
  localparam upc_t U_BUSY     = 4'd10;
  localparam upc_t U_DONE     = 4'd11;

  typedef enum logic [3:0] {
    A_NOP,
    A_ACCEPT,
    A_FEND,
    A_SCAN_INIT,
    A_SCAN_E,
    A_SCAN_F,
    A_ARM_FIN,
    A_READ_FIN,
    A_CLEAR,
    A_OVF,
    A_BUSY,
    A_EMIT
  } uact_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_NO_ARM,
    C_ACTIVE,
    C_DISABLED,
    C_SCAN_END_E,
    C_SCAN_END_F,
    C_OUT_FREE
  } ucond_t;

  // taken: go to target; not taken: stay or step to the next word
  typedef struct packed {
    uact_t  act;
    ucond_t cond;
    logic   stay;
    upc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      U_IDLE:     w = '{A_ACCEPT,    C_DISPATCH,   1'b1, U_IDLE};
      U_FEND:     w = '{A_FEND,      C_NO_ARM,     1'b0, U_DONE};
      U_ARM:      w = '{A_SCAN_INIT, C_ACTIVE,     1'b0, U_DONE};
      U_SCAN_E:   w = '{A_SCAN_E,    C_SCAN_END_E, 1'b1, U_ARM_FIN};
      U_ARM_FIN:  w = '{A_ARM_FIN,   C_ALWAYS,     1'b0, U_DONE};
      U_READ:     w = '{A_SCAN_INIT, C_DISABLED,   1'b0, U_DONE};
      U_SCAN_F:   w = '{A_SCAN_F,    C_SCAN_END_F, 1'b1, U_READ_FIN};
      U_READ_FIN: w = '{A_READ_FIN,  C_ALWAYS,     1'b0, U_DONE};
      U_CLEAR:    w = '{A_CLEAR,     C_ALWAYS,     1'b0, U_DONE};
      U_OVF:      w = '{A_OVF,       C_ALWAYS,     1'b0, U_DONE};
      U_BUSY:     w = '{A_BUSY,      C_ALWAYS,     1'b0, U_DONE};
      U_DONE:     w = '{A_EMIT,      C_OUT_FREE,   1'b1, U_IDLE};
      default:    w = '{A_NOP,       C_ALWAYS,     1'b0, U_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each op's routine
  function automatic upc_t op_entry(input logic [2:0] code);
    upc_t p;
    unique case (code)
      OP_FRAME_END: p = U_FEND;
      OP_ARM_NEXT:  p = U_ARM;
      OP_READ:      p = U_READ;
      OP_CLEAR:     p = U_CLEAR;
      OP_OVERFLOW:  p = U_OVF;
      OP_BUSY:      p = U_BUSY;
      default:      p = U_DONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stat_buffer_pool_oldest_select.sv
// ----------------------------------------------------------------------------
// stat_buffer_pool_oldest_select
// Statistics buffer pool: stamps and releases the active buffer on frame end,
// picks a new active buffer, and hands out the oldest full buffer on read.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | op, frame_count, config_count,
//           |                      | result_done, data_intact, engine_enabled
//  out      | out_valid/out_ready  | status, buf_index, ret_frame,
//           |                      | ret_config, active_present
//
//  one request at a time: an ignored op code goes straight to its result, a read
//  scans the buffers, and a frame end or an arm may scan them for a new pick; the
//  scan steps through the buffers one per cycle with a single stamp comparator.
//  the result sits in an output register; the next request is taken while it
//  waits, and the sequencer holds in its final step if it is still unread.
//  synchronous reset empties all buffers, drops the active buffer and
//  clears the error count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module stat_buffer_pool_oldest_select
  import sbpos_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   op,
  input  wire logic [31:0]  frame_count,
  input  wire logic [31:0]  config_count,
  input  wire logic         result_done,
  input  wire logic         data_intact,
  input  wire logic         engine_enabled,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        status,
  output logic [2:0]        buf_index,
  output logic [31:0]       ret_frame,
  output logic [31:0]       ret_config,
  output logic              active_present
);

  localparam logic [BUF_W-1:0] LAST_IDX = BUF_W'(NUM_BUFFERS - 1);

  upc_t   upc, upc_next;
  uword_t uw;

  // pool state
  logic [NUM_BUFFERS-1:0] full_flags;
  logic [STAMP_W-1:0]     frame_stamps  [NUM_BUFFERS];
  logic [STAMP_W-1:0]     config_stamps [NUM_BUFFERS];
  logic [BUF_W-1:0]       active_index;
  logic                   active_valid;
  logic [1:0]             error_count;

  // latched request
  logic [STAMP_W-1:0] req_frame, req_config;
  logic               req_done, req_intact, req_en;

  // scan datapath
  logic [BUF_W-1:0]   idx;
  logic               found;
  logic [BUF_W-1:0]   found_idx;
  logic [STAMP_W-1:0] best_frame, best_config;
  logic [1:0]         st;
  logic               read_hit;

  logic               elig, empty_hit, full_cand, idx_last;
  logic [STAMP_W-1:0] diff;
  logic               cond_true;

  assign uw = ucode_rom(upc);

  always_comb begin
    elig      = !(active_valid && (idx == active_index));
    diff      = frame_stamps[idx] - best_frame;
    empty_hit = elig && !full_flags[idx];
    // strict older only, so equal stamps keep the lower index
    full_cand = elig && full_flags[idx] && (!found || diff[STAMP_W-1]);
    idx_last  = (idx == LAST_IDX);
  end

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_DISPATCH:   cond_true = in_valid;
      C_NO_ARM:     cond_true = !((error_count == 2'd0) && req_done && req_en);
      C_ACTIVE:     cond_true = active_valid;
      C_DISABLED:   cond_true = !req_en;
      C_SCAN_END_E: cond_true = idx_last || empty_hit;
      C_SCAN_END_F: cond_true = idx_last;
      C_OUT_FREE:   cond_true = !out_valid || out_ready;
      default:      cond_true = 1'b1;
    endcase
  end

  always_comb begin
    priority if (uw.cond == C_DISPATCH && cond_true) begin
      upc_next = op_entry(op);
    end else if (cond_true) begin
      upc_next = uw.target;
    end else if (uw.stay) begin
      upc_next = upc;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  assign in_ready = (uw.act == A_ACCEPT);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= U_IDLE;
      full_flags   <= '0;
      active_index <= '0;
      active_valid <= 1'b0;
      error_count  <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      upc <= upc_next;
      if (uw.act == A_EMIT && cond_true) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (uw.act)
        A_FEND: begin
          if (error_count != 2'd0) begin
            error_count <= error_count - 2'd1;
          end else if (req_done && req_en && active_valid && req_intact) begin
            full_flags[active_index] <= 1'b1;
            active_valid             <= 1'b0;
          end
        end
        A_ARM_FIN: begin
          if (found) begin
            active_index <= found_idx;
            active_valid <= 1'b1;
          end
        end
        A_READ_FIN: begin
          if (found) begin
            full_flags[found_idx] <= 1'b0;
          end
        end
        A_CLEAR: full_flags  <= '0;
        A_OVF:   error_count <= 2'd2;
        A_BUSY:  error_count <= 2'd1;
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    unique case (uw.act)
      A_ACCEPT: begin
        if (in_valid) begin
          req_frame  <= frame_count;
          req_config <= config_count;
          req_done   <= result_done;
          req_intact <= data_intact;
          req_en     <= engine_enabled;
          read_hit   <= 1'b0;
          priority if (op == OP_BUSY) begin
            st <= ST_NO_BUF;
          end else if (op == OP_READ) begin
            st <= ST_NONE;
          end else begin
            st <= ST_OK;
          end
        end
      end
      A_FEND: begin
        if (error_count == 2'd0 && req_done && req_en && active_valid && req_intact) begin
          frame_stamps[active_index]  <= req_frame;
          config_stamps[active_index] <= req_config;
          st                          <= ST_OK;
        end else begin
          st <= ST_NO_BUF;
        end
      end
      A_SCAN_INIT: begin
        idx   <= '0;
        found <= 1'b0;
      end
      A_SCAN_E: begin
        idx <= idx + BUF_W'(1);
        if (empty_hit) begin
          found     <= 1'b1;
          found_idx <= idx;
        end else if (full_cand) begin
          found       <= 1'b1;
          found_idx   <= idx;
          best_frame  <= frame_stamps[idx];
          best_config <= config_stamps[idx];
        end
      end
      A_SCAN_F: begin
        idx <= idx + BUF_W'(1);
        if (full_cand) begin
          found       <= 1'b1;
          found_idx   <= idx;
          best_frame  <= frame_stamps[idx];
          best_config <= config_stamps[idx];
        end
      end
      A_READ_FIN: begin
        if (found) begin
          read_hit <= 1'b1;
          st       <= ST_OK;
        end
      end
      A_EMIT: begin
        if (cond_true) begin
          status         <= st;
          ret_frame      <= read_hit ? best_frame : '0;
          ret_config     <= read_hit ? best_config : '0;
          active_present <= active_valid;
          priority if (read_hit) begin
            buf_index <= 3'(found_idx);
          end else if (active_valid) begin
            buf_index <= 3'(active_index);
          end else begin
            buf_index <= 3'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // a successful read leaves the returned buffer empty
  a_read_empties: assert property (@(posedge clk) disable iff (rst)
    (uw.act == A_READ_FIN && found) |=> !full_flags[$past(found_idx)])
    else $error("read did not empty the returned buffer");

  // a found pick always leaves an active buffer
  a_arm_sets_active: assert property (@(posedge clk) disable iff (rst)
    (uw.act == A_ARM_FIN && found) |=> active_valid)
    else $error("pick did not set an active buffer");

  // a read never hands out the active buffer
  a_read_not_active: assert property (@(posedge clk) disable iff (rst)
    (uw.act == A_READ_FIN && found) |-> !(active_valid && found_idx == active_index))
    else $error("read returned the active buffer");

  // only a result with status ok carries stamps of a returned buffer
  a_stamp_status: assert property (@(posedge clk) disable iff (rst)
    (uw.act == A_EMIT && cond_true && read_hit) |-> (st == ST_OK))
    else $error("returned buffer with non-ok status");

endmodule

`default_nettype wire

// File: tb/sbpos_tb_pkg.sv
// ----------------------------------------------------------------------------
// sbpos_tb_pkg
// Request and result types for the buffer pool testbench, and a scoreboard
// that tracks the pool state, predicts each result and compares the block's
// results in order.
// ----------------------------------------------------------------------------

package sbpos_tb_pkg;

  import sbpos_pkg::*;

  // op codes that the block ignores
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] frame;
    logic [31:0] cfg_count;
    logic        done;
    logic        intact;
    logic        enabled;
  } pool_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  buf_idx;
    logic [31:0] frame_stamp;
    logic [31:0] config_stamp;
    logic        active;
  } pool_result_t;

  class pool_scoreboard;
    logic             slot_full   [NUM_BUFFERS];
    logic [31:0]      slot_frame  [NUM_BUFFERS];
    logic [31:0]      slot_config [NUM_BUFFERS];
    logic [BUF_W-1:0] live_idx;
    logic             live_valid;
    logic [1:0]       drop_count;
    pool_result_t     pending_results[$];
    int errors;
    int n_results;
    int n_stamped;
    int n_returned;
    int n_dropped;
    int n_reused;
    int n_empty_reads;

    function new();
      foreach (slot_full[i]) begin
        slot_full[i]   = 1'b0;
        slot_frame[i]  = '0;
        slot_config[i] = '0;
      end
      live_idx   = '0;
      live_valid = 1'b0;
      drop_count = '0;
    endfunction

    // wrap-aware: a is older when a - b has its top bit set
    function bit stamp_is_older(logic [31:0] a, logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
    endfunction

    // first empty slot when take_empty, else the oldest full one; the live
    // slot is never a candidate
    function int pick_slot(bit take_empty);
      int found;
      found = -1;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (live_valid && i == int'(live_idx)) continue;
        if (!slot_full[i]) begin
          if (take_empty) return i;
          continue;
        end
        if (found < 0 || stamp_is_older(slot_frame[i], slot_frame[found])) found = i;
      end
      return found;
    endfunction

    function void arm_next_slot();
      int n;
      if (live_valid) return;
      n = pick_slot(1'b1);
      if (n >= 0) begin
        if (slot_full[n]) n_reused++;
        live_idx   = BUF_W'(n);
        live_valid = 1'b1;
      end
    endfunction

    // updates the pool for an accepted request and queues its result
    function void note_request(pool_request_t r);
      pool_result_t want;
      int           hit_idx;
      bit           hit;
      want    = '0;
      hit_idx = -1;
      hit     = 1'b0;
      case (r.op)
        OP_FRAME_END: begin
          want.status = ST_NO_BUF;
          if (drop_count != 0) begin
            drop_count = drop_count - 2'd1;
            n_dropped++;
          end else if (r.done && r.enabled) begin
            if (live_valid && r.intact) begin
              slot_frame[live_idx]  = r.frame;
              slot_config[live_idx] = r.cfg_count;
              slot_full[live_idx]   = 1'b1;
              live_valid            = 1'b0;
              want.status           = ST_OK;
              n_stamped++;
            end
            arm_next_slot();
          end
        end
        OP_ARM_NEXT: arm_next_slot();
        OP_READ: begin
          want.status = ST_NONE;
          if (r.enabled) hit_idx = pick_slot(1'b0);
          if (hit_idx >= 0) begin
            hit               = 1'b1;
            want.status       = ST_OK;
            want.frame_stamp  = slot_frame[hit_idx];
            want.config_stamp = slot_config[hit_idx];
            slot_full[hit_idx] = 1'b0;
            n_returned++;
          end else begin
            n_empty_reads++;
          end
        end
        OP_CLEAR: foreach (slot_full[i]) slot_full[i] = 1'b0;
        OP_OVERFLOW: drop_count = 2'd2;
        OP_BUSY: begin
          drop_count  = 2'd1;
          want.status = ST_NO_BUF;
        end
        default: ;
      endcase
      if (hit) want.buf_idx = 3'(hit_idx);
      else want.buf_idx = live_valid ? 3'(live_idx) : 3'd0;
      want.active = live_valid;
      pending_results.push_back(want);
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch at result %0d: %s", n_results, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [2:0] idx, logic [31:0] fstamp,
                      logic [31:0] cstamp, logic act);
      pool_result_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d index %0d", st, idx));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (idx !== want.buf_idx)
        report($sformatf("buf_index %0d, expected %0d", idx, want.buf_idx));
      if (fstamp !== want.frame_stamp)
        report($sformatf("ret_frame %h, expected %h", fstamp, want.frame_stamp));
      if (cstamp !== want.config_stamp)
        report($sformatf("ret_config %h, expected %h", cstamp, want.config_stamp));
      if (act !== want.active)
        report($sformatf("active_present %b, expected %b", act, want.active));
    endtask
  endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives frame ends, arms, reads, clears and error events into the buffer
// pool with random gaps and output stalls, and checks every result against
// the scoreboard's prediction of the pool.
// ----------------------------------------------------------------------------

module tb_top
  import sbpos_pkg::*, sbpos_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1530;
  localparam int QUIET_TAIL = 200;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [31:0] frame_count;
  logic [31:0] config_count;
  logic        result_done;
  logic        data_intact;
  logic        engine_enabled;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [2:0]  buf_index;
  logic [31:0] ret_frame;
  logic [31:0] ret_config;
  logic        active_present;

  pool_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int             n_sent = 0;
  logic [31:0]    frame_ctr = 32'hFFFF_FF00;

  always #2 clk = ~clk;

  stat_buffer_pool_oldest_select dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .frame_count    (frame_count),
    .config_count   (config_count),
    .result_done    (result_done),
    .data_intact    (data_intact),
    .engine_enabled (engine_enabled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .buf_index      (buf_index),
    .ret_frame      (ret_frame),
    .ret_config     (ret_config),
    .active_present (active_present)
  );

  function automatic pool_request_t request_of(logic [2:0] code, logic [31:0] fnum,
                                               logic [31:0] cnum, logic d, logic i,
                                               logic e);
    pool_request_t r;
    r.op        = code;
    r.frame     = fnum;
    r.cfg_count = cnum;
    r.done      = d;
    r.intact    = i;
    r.enabled   = e;
    return r;
  endfunction

  // mostly well-formed frames with a running frame number, plus reads at the
  // given share and some error events and noise
  function automatic pool_request_t random_request(int read_pct);
    pool_request_t r;
    int            roll;
    roll        = $urandom_range(0, 99);
    r.frame     = $urandom;
    r.cfg_count = $urandom;
    r.done      = ($urandom_range(0, 11) != 0);
    r.intact    = ($urandom_range(0, 11) != 0);
    r.enabled   = ($urandom_range(0, 11) != 0);
    if (roll < read_pct) r.op = OP_READ;
    else if (roll < read_pct + 8) r.op = OP_ARM_NEXT;
    else if (roll < read_pct + 11) r.op = OP_OVERFLOW;
    else if (roll < read_pct + 14) r.op = OP_BUSY;
    else if (roll < read_pct + 16) r.op = OP_CLEAR;
    else if (roll < read_pct + 17) r.op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    else begin
      r.op = OP_FRAME_END;
      case ($urandom_range(0, 19))
        0: frame_ctr = $urandom;
        1: frame_ctr = frame_ctr - $urandom_range(1, 40);
        2: frame_ctr = frame_ctr + 32'h7FFF_FFF0 + $urandom_range(0, 31);
        3: ;  // same stamp again
        default: frame_ctr = frame_ctr + 32'd1;
      endcase
      r.frame = frame_ctr;
    end
    return r;
  endfunction

  task automatic send_request(input pool_request_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= r.op;
    frame_count    <= r.frame;
    config_count   <= r.cfg_count;
    result_done    <= r.done;
    data_intact    <= r.intact;
    engine_enabled <= r.enabled;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_request(r);
    n_sent++;
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready)
        sb.check_result(status, buf_index, ret_frame, ret_config, active_present);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int read_pct;
    read_pct = 20;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    op             <= OP_FRAME_END;
    frame_count    <= '0;
    config_count   <= '0;
    result_done    <= 1'b0;
    data_intact    <= 1'b0;
    engine_enabled <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty pool, frame end with nothing armed, ignored codes
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd5, 32'd9, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_UNUSED_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_UNUSED_7, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    // stamps across the wrap, a corrupted frame, then an equal stamp
    send_request(request_of(OP_FRAME_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd0, 32'd1, 1'b1, 1'b0, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd0, 32'h1234_5678, 1'b1, 1'b1, 1'b1));
    // read with the engine off, then oldest-first reads
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0));
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));
    // overflow drops two frames, busy drops one
    send_request(request_of(OP_OVERFLOW, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    send_request(request_of(OP_FRAME_END, 32'd10, 32'd10, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd11, 32'd11, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_BUSY, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    send_request(request_of(OP_FRAME_END, 32'd12, 32'd12, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_CLEAR, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    send_request(request_of(OP_ARM_NEXT, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    send_request(request_of(OP_FRAME_END, 32'd13, 32'd13, 1'b0, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'd14, 32'd14, 1'b1, 1'b1, 1'b0));
    // half-range stamps
    send_request(request_of(OP_FRAME_END, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_FRAME_END, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));
    send_request(request_of(OP_READ, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1));

    // each segment picks a random read share, so some fill and some drain the pool
    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       read_pct = 5;
          1:       read_pct = 20;
          default: read_pct = 45;
        endcase
        idle_on = (k < NUM_RANDOM - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      end
      send_request(random_request(read_pct));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests, %0d results: %0d frames stamped, %0d dropped, %0d buffers read",
             n_sent, sb.n_results, sb.n_stamped, sb.n_dropped, sb.n_returned);
    $display("%0d full buffers re-armed, %0d reads with nothing queued, %0d mismatches",
             sb.n_reused, sb.n_empty_reads, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
